// ----- src/dkwq_pkg.sv -----
`default_nettype none

package dkwq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 64;
    localparam int unsigned KEY_W           = 16;
    localparam int unsigned HANDLE_W        = 16;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_POPPED    = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_FULL      = 3'd6,
        ST_CLEARED   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_APPEND,
        S_POP,
        S_FREE,
        S_DONE
    } state_t;

    // per-field write enables of the slot store
    typedef struct packed {
        logic key;
        logic handle;
        logic link;
    } wr_en_t;

    // one finished result, handed from the sequencer to the output stage
    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key_x;
        logic [KEY_W-1:0]    key_z;
    } res_t;

endpackage

`default_nettype wire

// ----- src/dkwq_store.sv -----
`default_nettype none

module dkwq_store #(
    parameter int unsigned QUEUE_DEPTH = dkwq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned AW          = $clog2(QUEUE_DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic [dkwq_pkg::KEY_W-1:0]         rd_kx,
    output logic [dkwq_pkg::KEY_W-1:0]         rd_kz,
    output logic [dkwq_pkg::HANDLE_W-1:0]      rd_handle,
    output logic [AW-1:0]                      rd_next,
    input  wire dkwq_pkg::wr_en_t              wr_en,
    input  wire logic [AW-1:0]                 wr_data_addr,
    input  wire logic [dkwq_pkg::KEY_W-1:0]    wr_kx,
    input  wire logic [dkwq_pkg::KEY_W-1:0]    wr_kz,
    input  wire logic [dkwq_pkg::HANDLE_W-1:0] wr_handle,
    input  wire logic [AW-1:0]                 wr_next_addr,
    input  wire logic [AW-1:0]                 wr_next
);
    import dkwq_pkg::*;

    logic [KEY_W-1:0]    mem_kx     [QUEUE_DEPTH];
    logic [KEY_W-1:0]    mem_kz     [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] mem_handle [QUEUE_DEPTH];
    logic [AW-1:0]       mem_next   [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en.key) begin
            mem_kx[wr_data_addr] <= wr_kx;
            mem_kz[wr_data_addr] <= wr_kz;
        end
        if (wr_en.handle) begin
            mem_handle[wr_data_addr] <= wr_handle;
        end
        if (wr_en.link) begin
            mem_next[wr_next_addr] <= wr_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_kx     <= mem_kx[rd_addr];
        rd_kz     <= mem_kz[rd_addr];
        rd_handle <= mem_handle[rd_addr];
        rd_next   <= mem_next[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/dkwq_seq.sv -----
`default_nettype none

module dkwq_seq #(
    parameter int unsigned QUEUE_DEPTH = dkwq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
    parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_command,
    input  wire logic [dkwq_pkg::KEY_W-1:0]    s_key_x,
    input  wire logic [dkwq_pkg::KEY_W-1:0]    s_key_z,
    input  wire logic [dkwq_pkg::HANDLE_W-1:0] s_entry_handle,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output dkwq_pkg::res_t                     res,
    output logic [CW-1:0]                      occupancy,
    output logic [AW-1:0]                      rd_addr,
    input  wire logic [dkwq_pkg::KEY_W-1:0]    rd_kx,
    input  wire logic [dkwq_pkg::KEY_W-1:0]    rd_kz,
    input  wire logic [dkwq_pkg::HANDLE_W-1:0] rd_handle,
    input  wire logic [AW-1:0]                 rd_next,
    output dkwq_pkg::wr_en_t                   wr_en,
    output logic [AW-1:0]                      wr_data_addr,
    output logic [dkwq_pkg::KEY_W-1:0]         wr_kx,
    output logic [dkwq_pkg::KEY_W-1:0]         wr_kz,
    output logic [dkwq_pkg::HANDLE_W-1:0]      wr_handle,
    output logic [AW-1:0]                      wr_next_addr,
    output logic [AW-1:0]                      wr_next
);
    import dkwq_pkg::*;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_W-1:0]    kx_reg, kx_next;
    logic [KEY_W-1:0]    kz_reg, kz_next;
    logic [HANDLE_W-1:0] hd_reg, hd_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       free_head_reg, free_head_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       prev_reg, prev_next;
    logic [CW-1:0]       step_reg, step_next;
    logic [AW-1:0]       at_reg, at_next;
    res_t                res_reg, res_next;

    logic          key_match;
    logic          walk_last;
    logic          count_zero;
    logic          store_full;
    logic          from_free;
    logic [AW-1:0] new_slot;
    cmd_t          in_cmd;

    // the shared key comparator; every walk step goes through it
    assign key_match  = (rd_kx == kx_reg) && (rd_kz == kz_reg);
    assign walk_last  = (step_reg == count_reg - CW'(1));
    assign count_zero = (count_reg == '0);
    assign store_full = (count_reg == CW'(QUEUE_DEPTH));
    assign from_free  = (fill_reg != count_reg);
    assign new_slot   = from_free ? free_head_reg : fill_reg[AW-1:0];
    assign in_cmd     = cmd_t'(s_command);

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign occupancy = count_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (in_cmd)
                        CMD_PUSH:   state_next = count_zero ? S_ALLOC : S_WALK;
                        CMD_REMOVE: state_next = count_zero ? S_DONE : S_WALK;
                        CMD_POP:    state_next = count_zero ? S_DONE : S_POP;
                        CMD_CLEAR:  state_next = S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                if (key_match) begin
                    state_next = (cmd_reg == CMD_PUSH) ? S_DONE : S_FREE;
                end else if (walk_last) begin
                    if (cmd_reg == CMD_PUSH && !store_full) begin
                        state_next = S_ALLOC;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ALLOC:  state_next = S_APPEND;
            S_APPEND: state_next = S_DONE;
            S_POP:    state_next = S_FREE;
            S_FREE:   state_next = S_DONE;
            S_DONE:   state_next = res_ready ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next       = cmd_reg;
        kx_next        = kx_reg;
        kz_next        = kz_reg;
        hd_next        = hd_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        step_next      = step_reg;
        at_next        = at_reg;
        res_next       = res_reg;
        rd_addr        = head_reg;
        wr_en          = '0;
        wr_data_addr   = cur_reg;
        wr_kx          = kx_reg;
        wr_kz          = kz_reg;
        wr_handle      = hd_reg;
        wr_next_addr   = prev_reg;
        wr_next        = rd_next;

        unique case (state_reg)
            S_IDLE: begin
                // keep reading the head so a pop finds its data next cycle
                rd_addr = head_reg;
                if (s_valid) begin
                    cmd_next        = in_cmd;
                    kx_next         = s_key_x;
                    kz_next         = s_key_z;
                    hd_next         = s_entry_handle;
                    cur_next        = head_reg;
                    prev_next       = head_reg;
                    step_next       = '0;
                    res_next.handle = '0;
                    res_next.key_x  = '0;
                    res_next.key_z  = '0;
                    res_next.status = ST_NOT_FOUND;
                    if (in_cmd == CMD_POP) begin
                        res_next.status = ST_EMPTY;
                    end else if (in_cmd == CMD_CLEAR) begin
                        res_next.status = ST_CLEARED;
                        head_next       = '0;
                        tail_next       = '0;
                        count_next      = '0;
                        fill_next       = '0;
                    end
                end
            end
            S_WALK: begin
                rd_addr = rd_next;
                if (key_match) begin
                    at_next = cur_reg;
                    if (cmd_reg == CMD_PUSH) begin
                        wr_en.handle    = 1'b1;
                        wr_data_addr    = cur_reg;
                        res_next.status = ST_UPDATED;
                    end else begin
                        // unlink: head moves, tail steps back, or predecessor skips
                        if (step_reg == '0) begin
                            if (count_reg != CW'(1)) begin
                                head_next = rd_next;
                            end
                        end else if (cur_reg == tail_reg) begin
                            tail_next = prev_reg;
                        end else begin
                            wr_en.link   = 1'b1;
                            wr_next_addr = prev_reg;
                            wr_next      = rd_next;
                        end
                        count_next = count_reg - CW'(1);
                        if (count_reg == CW'(1)) begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        res_next.status = ST_REMOVED;
                    end
                end else if (walk_last) begin
                    if (cmd_reg == CMD_PUSH) begin
                        res_next.status = store_full ? ST_FULL : ST_APPENDED;
                    end else begin
                        res_next.status = ST_NOT_FOUND;
                    end
                end else begin
                    cur_next  = rd_next;
                    prev_next = cur_reg;
                    step_next = step_reg + CW'(1);
                end
            end
            S_ALLOC: begin
                // fetch the free-list successor in case the slot comes from there
                rd_addr = free_head_reg;
            end
            S_APPEND: begin
                if (from_free) begin
                    free_head_next = rd_next;
                end else begin
                    fill_next = fill_reg + CW'(1);
                end
                wr_en.key    = 1'b1;
                wr_en.handle = 1'b1;
                wr_data_addr = new_slot;
                if (count_zero) begin
                    head_next = new_slot;
                end else begin
                    wr_en.link   = 1'b1;
                    wr_next_addr = tail_reg;
                    wr_next      = new_slot;
                end
                tail_next       = new_slot;
                count_next      = count_reg + CW'(1);
                res_next.status = ST_APPENDED;
            end
            S_POP: begin
                res_next.handle = rd_handle;
                res_next.key_x  = rd_kx;
                res_next.key_z  = rd_kz;
                res_next.status = ST_POPPED;
                at_next         = head_reg;
                count_next      = count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    head_next = rd_next;
                end
            end
            S_FREE: begin
                // push the released slot onto the free list
                wr_en.link     = 1'b1;
                wr_next_addr   = at_reg;
                wr_next        = free_head_reg;
                free_head_next = at_reg;
            end
            S_DONE: begin
                rd_addr = head_reg;
            end
            default: begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            free_head_reg <= '0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        kx_reg   <= kx_next;
        kz_reg   <= kz_next;
        hd_reg   <= hd_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        step_reg <= step_next;
        at_reg   <= at_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// ----- src/dedup_keyed_work_queue_unit.sv -----
// Sequence: from input transfer to m_valid, clear and a pop or remove on an empty queue pass only
//   the done state and the output register; a pop adds the pop and free states, a push into an
//   empty queue the alloc and append states; a key search first walks the queued entries.
// Flow: one command at a time; the next is taken once the last result has moved on to the output
//   register; the chain walk through the slot store read port takes one entry per cycle.
// Reset: aresetn is synchronous, active low; it empties the queue, no clearing pass is needed.
`default_nettype none

module dedup_keyed_work_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = dkwq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_command,
    input  wire logic signed [dkwq_pkg::KEY_W-1:0]    s_key_x,
    input  wire logic signed [dkwq_pkg::KEY_W-1:0]    s_key_z,
    input  wire logic [dkwq_pkg::HANDLE_W-1:0]        s_entry_handle,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [2:0]                                m_status,
    output logic [dkwq_pkg::HANDLE_W-1:0]             m_out_handle,
    output logic signed [dkwq_pkg::KEY_W-1:0]         m_out_key_x,
    output logic signed [dkwq_pkg::KEY_W-1:0]         m_out_key_z,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]          m_occupancy
);
    import dkwq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // slot store port
    logic [AW-1:0]       rd_addr;
    logic [KEY_W-1:0]    rd_kx;
    logic [KEY_W-1:0]    rd_kz;
    logic [HANDLE_W-1:0] rd_handle;
    logic [AW-1:0]       rd_next;
    wr_en_t              wr_en;
    logic [AW-1:0]       wr_data_addr;
    logic [KEY_W-1:0]    wr_kx;
    logic [KEY_W-1:0]    wr_kz;
    logic [HANDLE_W-1:0] wr_handle;
    logic [AW-1:0]       wr_next_addr;
    logic [AW-1:0]       wr_next;

    // finished result from the sequencer
    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic [CW-1:0] occupancy;

    // output register
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [HANDLE_W-1:0] m_handle_reg, m_handle_next;
    logic [KEY_W-1:0]    m_kx_reg, m_kx_next;
    logic [KEY_W-1:0]    m_kz_reg, m_kz_next;
    logic [CW-1:0]       m_occ_reg, m_occ_next;

    // The sequencer owns head, tail, count and the free list; slots live in the store.
    // Slots never handed out since the last clear are counted by a fill mark, released ones
    // are chained on a free list, so neither reset nor clear sweeps the store.
    dkwq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_key_x        (s_key_x),
        .s_key_z        (s_key_z),
        .s_entry_handle (s_entry_handle),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .occupancy      (occupancy),
        .rd_addr        (rd_addr),
        .rd_kx          (rd_kx),
        .rd_kz          (rd_kz),
        .rd_handle      (rd_handle),
        .rd_next        (rd_next),
        .wr_en          (wr_en),
        .wr_data_addr   (wr_data_addr),
        .wr_kx          (wr_kx),
        .wr_kz          (wr_kz),
        .wr_handle      (wr_handle),
        .wr_next_addr   (wr_next_addr),
        .wr_next        (wr_next)
    );

    dkwq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_store (
        .aclk         (aclk),
        .rd_addr      (rd_addr),
        .rd_kx        (rd_kx),
        .rd_kz        (rd_kz),
        .rd_handle    (rd_handle),
        .rd_next      (rd_next),
        .wr_en        (wr_en),
        .wr_data_addr (wr_data_addr),
        .wr_kx        (wr_kx),
        .wr_kz        (wr_kz),
        .wr_handle    (wr_handle),
        .wr_next_addr (wr_next_addr),
        .wr_next      (wr_next)
    );

    // The output register frees the sequencer: it can take the next command while the
    // previous result still waits for its transfer.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_handle_next = m_handle_reg;
        m_kx_next     = m_kx_reg;
        m_kz_next     = m_kz_reg;
        m_occ_next    = m_occ_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        // load a finished result once the slot is free
        if (res_valid && res_ready) begin
            m_valid_next  = 1'b1;
            m_status_next = res.status;
            m_handle_next = res.handle;
            m_kx_next     = res.key_x;
            m_kz_next     = res.key_z;
            m_occ_next    = occupancy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_handle_reg <= m_handle_next;
        m_kx_reg     <= m_kx_next;
        m_kz_reg     <= m_kz_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_handle = m_handle_reg;
    assign m_out_key_x  = m_kx_reg;
    assign m_out_key_z  = m_kz_reg;
    assign m_occupancy  = m_occ_reg;

endmodule

`default_nettype wire

// ----- src/dkwq_checker.sv -----
`default_nettype none

module dkwq_checker #(
    parameter int unsigned QUEUE_DEPTH = dkwq_pkg::DEF_QUEUE_DEPTH
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic [2:0]                           m_status,
    input wire logic [dkwq_pkg::HANDLE_W-1:0]        m_out_handle,
    input wire logic signed [dkwq_pkg::KEY_W-1:0]    m_out_key_x,
    input wire logic signed [dkwq_pkg::KEY_W-1:0]    m_out_key_z,
    input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]     m_occupancy
);
    import dkwq_pkg::*;

    // one command at a time: a transfer closes the input side
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input side still ready after a transfer");

    a_occupancy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_occupancy <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_empty_states: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_CLEARED || m_status == ST_EMPTY) |-> m_occupancy == '0)
        else $error("clear or empty pop left entries queued");

    a_entry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_POPPED
            |-> m_out_handle == '0 && m_out_key_x == '0 && m_out_key_z == '0)
        else $error("entry fields nonzero on a result that is not a pop");

    a_full_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL
            |-> m_occupancy == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("full reported below queue depth");

endmodule

bind dedup_keyed_work_queue_unit dkwq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dkwq_checker (.*);

`default_nettype wire

// ----- bench/dedup_keyed_work_queue_unit_tb.sv -----
`timescale 1ns / 100ps

module dedup_keyed_work_queue_unit_tb;

    import dkwq_pkg::*;

    localparam int QUEUE_DEPTH   = DEF_QUEUE_DEPTH;
    localparam int OCC_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ITEM_TARGET   = 1200;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CALM_FIRST    = 500;
    localparam int CALM_LAST     = 650;
    localparam int POOL_SIZE     = 24;
    localparam int DIR_ROWS      = 21;

    // One queued entry: key pair plus the handle stored with it. Also used to
    // carry the payload of one command toward the input channel.
    typedef struct packed {
        logic [KEY_W-1:0]    kx;
        logic [KEY_W-1:0]    kz;
        logic [HANDLE_W-1:0] hd;
    } queued_work_t;

    // One result as it should leave the block.
    typedef struct packed {
        status_t             st;
        logic [HANDLE_W-1:0] hd;
        logic [KEY_W-1:0]    kx;
        logic [KEY_W-1:0]    kz;
        logic [OCC_W-1:0]    occ;
    } work_result_t;

    // One row of the directed table; the expected fields count only where
    // fixed is set, every other row goes through the queue model.
    typedef struct {
        cmd_t                cmd;
        logic [KEY_W-1:0]    kx;
        logic [KEY_W-1:0]    kz;
        logic [HANDLE_W-1:0] hd;
        bit                  fixed;
        status_t             st;
        logic [HANDLE_W-1:0] ohd;
        logic [KEY_W-1:0]    okx;
        logic [KEY_W-1:0]    okz;
        logic [OCC_W-1:0]    occ;
    } dir_row_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX,
        MODE_NOISE
    } traffic_mode_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_command;
    logic signed [KEY_W-1:0]    s_key_x;
    logic signed [KEY_W-1:0]    s_key_z;
    logic [HANDLE_W-1:0]        s_entry_handle;
    logic                       m_valid;
    logic                       m_ready;
    logic [2:0]                 m_status;
    logic [HANDLE_W-1:0]        m_out_handle;
    logic signed [KEY_W-1:0]    m_out_key_x;
    logic signed [KEY_W-1:0]    m_out_key_z;
    logic [OCC_W-1:0]           m_occupancy;

    // Model of the queue contents in arrival order, and the results that the
    // block still owes, oldest first.
    queued_work_t  model_entries[$];
    work_result_t  awaited_results[$];
    work_result_t  oldest_result;
    queued_work_t  key_pool[POOL_SIZE];

    int  items_sent;
    int  results_checked;
    int  mismatches;
    int  stuck_cycles;
    int  hold_left;
    int  status_seen[8];
    bit  calm;
    bit  start_hold;
    bit  hold_done;

    // Directed table: extremes, every command, duplicate keys, one-coordinate
    // differences, removal at head, middle and tail, and the empty cases.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_POP,    16'h0000, 16'h0000, 16'h0000, 1'b1, ST_EMPTY,     16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'h0064, 16'h00C8, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0, 16'h0, 16'h0, 0},
        '{CMD_PUSH,   16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, ST_APPENDED,  16'h0, 16'h0, 16'h0, 1},
        '{CMD_PUSH,   16'h7FFF, 16'h8000, 16'h0000, 1'b1, ST_APPENDED,  16'h0, 16'h0, 16'h0, 2},
        '{CMD_PUSH,   16'h8000, 16'h7FFF, 16'h1234, 1'b1, ST_UPDATED,   16'h0, 16'h0, 16'h0, 2},
        '{CMD_PUSH,   16'h0000, 16'h0000, 16'hAAAA, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_PUSH,   16'hFFFF, 16'hFFFF, 16'h5555, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_PUSH,   16'h0000, 16'hFFFF, 16'h0F0F, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_PUSH,   16'hFFFF, 16'h0000, 16'hF0F0, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_POP,    16'h0000, 16'h0000, 16'h0000, 1'b1, ST_POPPED,
          16'h1234, 16'h8000, 16'h7FFF, 3},
        '{CMD_POP,    16'h0000, 16'h0000, 16'h0000, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_PUSH,   16'hFFFF, 16'h0000, 16'h0001, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_PUSH,   16'h0001, 16'h0001, 16'hC3C3, 1'b0, ST_APPENDED,  16'h0, 16'h0, 16'h0, 0},
        '{CMD_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_CLEARED,   16'h0, 16'h0, 16'h0, 0},
        '{CMD_POP,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_EMPTY,     16'h0, 16'h0, 16'h0, 0},
        '{CMD_REMOVE, 16'h0001, 16'h0001, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0, 16'h0, 16'h0, 0}
    };

    dedup_keyed_work_queue_unit #(
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_key_x        (s_key_x),
        .s_key_z        (s_key_z),
        .s_entry_handle (s_entry_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_handle   (m_out_handle),
        .m_out_key_x    (m_out_key_x),
        .m_out_key_z    (m_out_key_z),
        .m_occupancy    (m_occupancy)
    );

    // 8 ns clock, high then low.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Advance the queue model by one command and return the result it owes.
    // Keys match on raw 16-bit patterns; an existing key keeps its place.
    function automatic work_result_t queue_model_step(cmd_t cmd, queued_work_t item);
        work_result_t r;
        queued_work_t e;
        int           at;
        int           i;
        r  = '0;
        at = -1;
        for (i = 0; i < model_entries.size(); i++) begin
            if (at < 0 && model_entries[i].kx == item.kx && model_entries[i].kz == item.kz) begin
                at = i;
            end
        end
        case (cmd)
            CMD_PUSH: begin
                if (at >= 0) begin
                    e = model_entries[at];
                    e.hd = item.hd;
                    model_entries[at] = e;
                    r.st = ST_UPDATED;
                end else if (model_entries.size() >= QUEUE_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    model_entries.push_back(item);
                    r.st = ST_APPENDED;
                end
            end
            CMD_REMOVE: begin
                if (at >= 0) begin
                    model_entries.delete(at);
                    r.st = ST_REMOVED;
                end else begin
                    r.st = ST_NOT_FOUND;
                end
            end
            CMD_POP: begin
                if (model_entries.size() == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    e    = model_entries.pop_front();
                    r.hd = e.hd;
                    r.kx = e.kx;
                    r.kz = e.kz;
                    r.st = ST_POPPED;
                end
            end
            default: begin
                model_entries.delete();
                r.st = ST_CLEARED;
            end
        endcase
        r.occ = OCC_W'(model_entries.size());
        return r;
    endfunction

    // Pick a key: a queued one, one from the shared pool, or a fresh random
    // pair, by the given percentages. The handle is always random.
    function automatic queued_work_t pick_key(int queued_pct, int pool_pct);
        queued_work_t k;
        int           r;
        r = $urandom_range(99);
        if (model_entries.size() > 0 && r < queued_pct) begin
            k = model_entries[$urandom_range(model_entries.size() - 1)];
        end else if (r < queued_pct + pool_pct) begin
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            k.kx = 16'($urandom_range(65535));
            k.kz = 16'($urandom_range(65535));
        end
        k.hd = 16'($urandom_range(65535));
        return k;
    endfunction

    // Offer one command on the input channel and hold it until the transfer.
    // Valid is only dropped when an idle gap comes before the next command,
    // so it never sees two updates in one step.
    task automatic offer(cmd_t cmd, queued_work_t item, bit fixed, work_result_t fixed_res);
        work_result_t predicted;
        int           gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                gap++;
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_key_x        <= item.kx;
        s_key_z        <= item.kz;
        s_entry_handle <= item.hd;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        // Transfer taken at this edge: advance the model right away.
        predicted = queue_model_step(cmd, item);
        awaited_results.push_back(fixed ? fixed_res : predicted);
        items_sent++;
    endtask

    // Result side: random back-pressure, one long hold-off when asked, none
    // during the calm stretch.
    always @(posedge aclk) begin
        if (start_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check every result transfer against the oldest awaited result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_status]++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status %0d handle %h key %h/%h occupancy %0d",
                             m_status, m_out_handle, m_out_key_x, m_out_key_z, m_occupancy);
                end
            end else begin
                oldest_result = awaited_results.pop_front();
                results_checked++;
                if (m_status !== oldest_result.st || m_out_handle !== oldest_result.hd ||
                    m_out_key_x !== oldest_result.kx || m_out_key_z !== oldest_result.kz ||
                    m_occupancy !== oldest_result.occ) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at result %0d: exp st %0d hd %h key %h/%h occ %0d",
                                 results_checked, oldest_result.st, oldest_result.hd,
                                 oldest_result.kx, oldest_result.kz, oldest_result.occ);
                        $display("                         got st %0d hd %h key %h/%h occ %0d",
                                 m_status, m_out_handle, m_out_key_x, m_out_key_z,
                                 m_occupancy);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("watchdog: no transfer for %0d cycles, %0d results awaited",
                             stuck_cycles, awaited_results.size());
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    initial begin
        queued_work_t  item;
        work_result_t  fixed_res;
        traffic_mode_t mode;
        cmd_t          cmd;
        int            phase_len;
        int            n;
        int            r;

        // Drive every input to a known value before the first edge.
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_command      <= CMD_PUSH;
        s_key_x        <= '0;
        s_key_z        <= '0;
        s_entry_handle <= '0;
        m_ready        <= 1'b0;
        calm        = 1'b0;
        start_hold  = 1'b0;
        hold_done   = 1'b0;
        hold_left   = 0;
        items_sent  = 0;
        results_checked = 0;
        mismatches  = 0;
        stuck_cycles = 0;
        for (n = 0; n < 8; n++) begin
            status_seen[n] = 0;
        end

        // Shared key pool: extremes, pairs that differ in one coordinate, the rest random.
        key_pool[0] = '{16'h8000, 16'h7FFF, 16'h0};
        key_pool[1] = '{16'h7FFF, 16'h8000, 16'h0};
        key_pool[2] = '{16'h0000, 16'h0000, 16'h0};
        key_pool[3] = '{16'hFFFF, 16'hFFFF, 16'h0};
        key_pool[4] = '{16'h0005, 16'h0007, 16'h0};
        key_pool[5] = '{16'h0005, 16'hFFF9, 16'h0};
        key_pool[6] = '{16'h0007, 16'h0005, 16'h0};
        for (n = 7; n < POOL_SIZE; n++) begin
            key_pool[n].kx = 16'($urandom_range(65535));
            key_pool[n].kz = 16'($urandom_range(65535));
            key_pool[n].hd = '0;
        end

        // Hold reset once, then release it.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table.
        for (n = 0; n < DIR_ROWS; n++) begin
            item.kx       = dir_rows[n].kx;
            item.kz       = dir_rows[n].kz;
            item.hd       = dir_rows[n].hd;
            fixed_res.st  = dir_rows[n].st;
            fixed_res.hd  = dir_rows[n].ohd;
            fixed_res.kx  = dir_rows[n].okx;
            fixed_res.kz  = dir_rows[n].okz;
            fixed_res.occ = dir_rows[n].occ;
            offer(dir_rows[n].cmd, item, dir_rows[n].fixed, fixed_res);
        end

        // Drop valid and pause the sender until every awaited result is back.
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end

        // Fill the store to the brim; hold off the receiver early on so the
        // output side backs up and stalls the input.
        fixed_res = '0;
        offer(CMD_CLEAR, pick_key(0, 0), 1'b0, fixed_res);
        n = 0;
        while (model_entries.size() < QUEUE_DEPTH) begin
            offer(CMD_PUSH, pick_key(0, 0), 1'b0, fixed_res);
            n++;
            if (n == 8) begin
                start_hold = 1'b1;
            end
        end
        // New key into a full store, then an update of a queued key while full.
        offer(CMD_PUSH, pick_key(0, 0), 1'b0, fixed_res);
        offer(CMD_PUSH, pick_key(100, 0), 1'b0, fixed_res);

        // Random phases of well-formed traffic with random content, plus some noise.
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            mode = (r < 30) ? MODE_FILL : (r < 55) ? MODE_DRAIN :
                   (r < 90) ? MODE_MIX : MODE_NOISE;
            phase_len = $urandom_range(100, 30);
            for (n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
                calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
                r = $urandom_range(99);
                case (mode)
                    MODE_FILL: begin
                        cmd  = (r < 80) ? CMD_PUSH : (r < 90) ? CMD_POP :
                               (r < 98) ? CMD_REMOVE : CMD_CLEAR;
                        item = (cmd == CMD_PUSH) ? pick_key(20, 5) : pick_key(55, 20);
                    end
                    MODE_DRAIN: begin
                        cmd  = (r < 45) ? CMD_POP : (r < 80) ? CMD_REMOVE : CMD_PUSH;
                        item = (cmd == CMD_PUSH) ? pick_key(20, 50) : pick_key(55, 30);
                    end
                    MODE_MIX: begin
                        cmd  = (r < 45) ? CMD_PUSH : (r < 70) ? CMD_REMOVE :
                               (r < 95) ? CMD_POP : CMD_CLEAR;
                        item = (cmd == CMD_PUSH) ? pick_key(15, 60) : pick_key(50, 35);
                    end
                    default: begin
                        cmd  = cmd_t'($urandom_range(3));
                        item = pick_key(0, 0);
                    end
                endcase
                offer(cmd, item, 1'b0, fixed_res);
            end
        end
        calm = 1'b0;

        // Stop offering, wait for the last results, then let the block settle.
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d commands (directed table, fill to full, random phases)",
                 items_sent);
        $display("statuses seen: app %0d upd %0d rem %0d nf %0d pop %0d emp %0d full %0d clr %0d",
                 status_seen[ST_APPENDED], status_seen[ST_UPDATED], status_seen[ST_REMOVED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_POPPED], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_CLEARED]);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
